>>> src/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package wbps_pkg;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_SCAN  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_BYTE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OCCURRENCE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_OFFSET  = 3'd4;

  localparam logic [7:0]  WILDCARD_RESET = 8'h90;
  localparam logic [7:0]  COUNT_MAX      = 8'hFF;

  // One transaction after the cell row has consumed it.
  typedef struct packed {
    logic scan;
    logic clear;
    logic hit;
    logic last;
  } stage_t;

endpackage

`default_nettype wire

>>> src/wbps_cell.sv
// One cell of the match chain: a pattern byte and its partial-match bit.
// Depends on wbps_pkg.
`default_nettype none

module wbps_cell (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire logic       scan_i,
  input  wire logic       clear_i,
  input  wire logic       active_i,
  input  wire logic       prev_i,
  input  wire logic [7:0] data_i,
  input  wire logic       wc_en_i,
  input  wire logic [7:0] wc_byte_i,
  output logic            chain_o,
  output logic            chain_next_o
);
  import wbps_pkg::*;

  logic [7:0] pat_q;
  logic       chain_q;
  logic       byte_ok;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= data_i;
    end
  end

  assign byte_ok      = (pat_q == data_i) || (wc_en_i && (pat_q == wc_byte_i));
  assign chain_next_o = active_i && prev_i && byte_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= 1'b0;
    end else if (clear_i) begin
      chain_q <= 1'b0;
    end else if (scan_i) begin
      chain_q <= chain_next_o;
    end
  end

  assign chain_o = chain_q;

endmodule

`default_nettype wire

>>> src/wbps_tally.sv
// Match counting, scan position and the result output register.
// Depends on wbps_pkg for stage_t and COUNT_MAX.
`default_nettype none

module wbps_tally (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  input  wire wbps_pkg::stage_t s_i,
  output logic                 s_ready_o,
  input  wire logic [31:0]     addr_bias_i,
  input  wire logic [7:0]      occurrence_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 found_o,
  output logic [31:0]          match_address_o,
  output logic [7:0]           matches_seen_o
);
  import wbps_pkg::*;

  logic [31:0] pos_q, pos_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        fin_q, fin_d;
  logic        out_valid_q;
  logic        found_q;
  logic [31:0] addr_q;
  logic [7:0]  seen_q;

  logic [7:0]  target;
  logic        live;
  logic        found_now;
  logic        emit;
  logic        out_free;
  logic        s_fire;

  assign live      = s_i.scan && !fin_q;
  assign target    = (occurrence_i == 8'd0) ? 8'd1 : occurrence_i;
  assign found_now = live && s_i.hit && (cnt_d >= target);
  assign emit      = live && (found_now || s_i.last);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign s_ready_o = !emit || out_free;
  assign s_fire    = s_valid_i && s_ready_o;

  always_comb begin
    cnt_d = cnt_q;
    if (s_i.hit && (cnt_q != COUNT_MAX)) begin
      cnt_d = cnt_q + 8'd1;
    end
  end

  always_comb begin
    pos_d = pos_q;
    fin_d = fin_q;
    if (s_i.clear) begin
      pos_d = '0;
      fin_d = 1'b0;
    end else if (live) begin
      pos_d = pos_q + 32'd1;
      fin_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
      fin_q <= 1'b0;
    end else if (s_fire) begin
      pos_q <= pos_d;
      fin_q <= fin_d;
      if (s_i.clear) begin
        cnt_q <= '0;
      end else if (live) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s_fire && emit;
    end
  end

  // Match start is position minus (length - 1), folded into the bias.
  always_ff @(posedge clk_i) begin
    if (out_free && s_fire && emit) begin
      found_q <= found_now;
      addr_q  <= found_now ? (addr_bias_i + pos_q) : 32'd0;
      seen_q  <= cnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;
  assign matches_seen_o  = seen_q;

`ifndef SYNTHESIS
  a_emit_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && emit) |=> fin_q)
    else $error("scan not finished after a result");

  a_found_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && found_q) |-> (seen_q != 8'd0))
    else $error("found result with zero matches");

  a_miss_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (addr_q == 32'd0))
    else $error("not-found result with nonzero address");

  a_finished_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_q && !(s_valid_i && s_i.clear)) |-> !emit)
    else $error("result produced after scan finished");
`endif

endmodule

`default_nettype wire

>>> src/wildcard_byte_pattern_scanner_unit.sv
// Top level of the wildcard byte pattern scanner: config registers, cell row, tally.
// Depends on wbps_pkg, wbps_cell and wbps_tally.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  input   | in_valid_i, in_stall_o, mode_i, data_byte_i,         | in
//          | pattern_slot_i, last_byte_i                          |
//  result  | out_valid_o, out_stall_i, found_o, match_address_o,  | out
//          | matches_seen_o                                       |
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i    | in
//
// One transaction is accepted every cycle while in_stall_o is low; the cell row
// updates all partial matches when a scan is accepted, and a result passes
// through the stage register into the output register. Reset clears the
// chain and counters and returns the config registers to their defaults;
// pattern bytes hold garbage until loaded. A stalled result backs up one
// staging register and then raises in_stall_o; config writes are always taken.
`default_nettype none

module wildcard_byte_pattern_scanner_unit #(
  parameter int unsigned PATTERN_MAX = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      mode_i,
  input  wire logic [7:0]                      data_byte_i,
  input  wire logic [7:0]                      pattern_slot_i,
  input  wire logic                            last_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 found_o,
  output logic [31:0]                          match_address_o,
  output logic [7:0]                           matches_seen_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i
);
  import wbps_pkg::*;

  localparam int unsigned IDX_W = $clog2(PATTERN_MAX);

  logic [31:0] base_q;
  logic [7:0]  len_q;
  logic [7:0]  wc_q;
  logic [7:0]  occ_q;
  logic [31:0] offset_q;

  logic             accept;
  logic             scan_en;
  logic             clear_en;
  logic             load_en;
  logic             wc_en;
  logic [IDX_W-1:0] len_m1;
  logic [7:0]       len_m1_raw;
  logic [31:0]      addr_bias;

  logic [PATTERN_MAX-1:0] chain;
  logic [PATTERN_MAX-1:0] chain_next;

  logic    s_valid_q;
  stage_t  s_q;
  logic    s_ready;

  // Config registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      len_q    <= 8'd1;
      wc_q     <= WILDCARD_RESET;
      occ_q    <= 8'd1;
      offset_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_REGION_BASE:    base_q   <= cfg_data_i;
        REG_PATTERN_LENGTH: len_q    <= cfg_data_i[7:0];
        REG_WILDCARD_BYTE:  wc_q     <= cfg_data_i[7:0];
        REG_OCCURRENCE:     occ_q    <= cfg_data_i[7:0];
        REG_RESULT_OFFSET:  offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the length to 1..PATTERN_MAX and keep length minus one.
  assign len_m1_raw = (len_q == 8'd0) ? 8'd0 : (len_q - 8'd1);

  always_comb begin
    if (32'(len_q) > PATTERN_MAX) begin
      len_m1 = IDX_W'(PATTERN_MAX - 1);
    end else begin
      len_m1 = IDX_W'(len_m1_raw);
    end
  end

  assign addr_bias = base_q + offset_q - 32'(len_m1);
  assign wc_en     = (wc_q != 8'd0);

  // Input handshake.
  assign in_stall_o = s_valid_q && !s_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign scan_en    = accept && (mode_i == MODE_SCAN);
  assign clear_en   = accept && (mode_i == MODE_CLEAR);
  assign load_en    = accept && (mode_i == MODE_LOAD);

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = chain[k-1];
    end

    wbps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load_en && (pattern_slot_i == 8'(k))),
      .scan_i      (scan_en),
      .clear_i     (clear_en),
      .active_i    (IDX_W'(k) <= len_m1),
      .prev_i      (prev),
      .data_i      (data_byte_i),
      .wc_en_i     (wc_en),
      .wc_byte_i   (wc_q),
      .chain_o     (chain[k]),
      .chain_next_o(chain_next[k])
    );
  end

  // Stage register between the cell row and the tally.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (accept) begin
      s_valid_q <= 1'b1;
    end else if (s_ready) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q.scan  <= (mode_i == MODE_SCAN);
      s_q.clear <= (mode_i == MODE_CLEAR);
      s_q.hit   <= (mode_i == MODE_SCAN) && chain_next[len_m1];
      s_q.last  <= last_byte_i;
    end
  end

  wbps_tally u_tally (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_valid_q),
    .s_i            (s_q),
    .s_ready_o      (s_ready),
    .addr_bias_i    (addr_bias),
    .occurrence_i   (occ_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .match_address_o(match_address_o),
    .matches_seen_o (matches_seen_o)
  );

endmodule

`default_nettype wire
